/* rtl/cds_pkg.sv */
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler package
// Shared types, codes and helper functions for the scheduler modules.
// ----------------------------------------------------------------------------
package cds_pkg;

    // Default capacity of the sorted request store.
    localparam int MAX_REQUESTS_DEF = 32;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Reset value of the disk size register.
    localparam logic [16:0] DISK_SIZE_RST = 17'd200;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE  = 1'b1;

    // Step kinds carried by each result.
    localparam logic [1:0] KIND_SERVE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ZERO  = 2'd2;

    // Request transaction payload.
    typedef struct packed {
        logic [15:0] cylinder;
        logic        is_last;
    } t_req;

    // Result transaction payload.
    typedef struct packed {
        logic [15:0] position;
        logic [1:0]  step_kind;
        logic [17:0] total_seek;
        logic        overflow;
        logic        last;
    } t_result;

    // Active configuration as seen by the back part.
    typedef struct packed {
        logic [15:0] start_head;
        logic [15:0] last_cyl;
    } t_cfg;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAGS,
        ST_SPLIT,
        ST_UPPER,
        ST_END,
        ST_ZERO,
        ST_LOWER
    } t_back_state;

    // Last cylinder of the disk; zero acts as one, sizes above 65536 saturate.
    function automatic logic [15:0] f_last_cyl(input logic [16:0] disk_size);
        logic [16:0] v_dec;
        v_dec = disk_size - 17'd1;
        if (disk_size == 17'd0) begin
            f_last_cyl = 16'd0;
        end else if (disk_size > 17'd65536) begin
            f_last_cyl = 16'hFFFF;
        end else begin
            f_last_cyl = v_dec[15:0];
        end
    endfunction

    // Clamp a cylinder to the last cylinder.
    function automatic logic [15:0] f_clamp(input logic [15:0] cyl, input logic [15:0] lastc);
        f_clamp = (cyl > lastc) ? lastc : cyl;
    endfunction

    // Absolute distance between two cylinders.
    function automatic logic [15:0] f_dist(input logic [15:0] a, input logic [15:0] b);
        f_dist = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/cds_front.sv */
// ----------------------------------------------------------------------------
// C-SCAN scheduler front
// Holds the configuration registers, accepts requests and clamps them to the
// disk before they enter the queue.
// ----------------------------------------------------------------------------
module cds_front
    import cds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_req                 i_req,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [16:0]          i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_req                 o_push_data,
    output t_cfg                 o_cfg
);

    logic [15:0] r_start_head;
    logic [16:0] r_disk_size;
    logic [15:0] w_last_cyl;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= 16'd0;
            r_disk_size  <= DISK_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_HEAD: r_start_head <= i_cfg_data[15:0];
                CFG_DISK_SIZE:  r_disk_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_last_cyl = f_last_cyl(r_disk_size);

    // A request is accepted whenever the queue has room.
    assign o_busy               = i_q_full;
    assign o_push               = i_start && !i_q_full;
    assign o_push_data.cylinder = f_clamp(i_req.cylinder, w_last_cyl);
    assign o_push_data.is_last  = i_req.is_last;

    assign o_cfg.start_head = r_start_head;
    assign o_cfg.last_cyl   = w_last_cyl;

endmodule

/* rtl/cds_queue.sv */
// ----------------------------------------------------------------------------
// C-SCAN scheduler request queue
// Short FIFO that decouples request intake from insertion and emission.
// ----------------------------------------------------------------------------
module cds_queue
    import cds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_push_data,
    input  logic i_pop,
    output t_req o_pop_data,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/cds_back.sv */
// ----------------------------------------------------------------------------
// C-SCAN scheduler back
// Inserts requests into a row of sorted cells and, when a batch ends, walks
// the cells to emit the C-SCAN service order with the running seek total.
// ----------------------------------------------------------------------------
module cds_back
    import cds_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_req    i_q_data,
    output logic    o_pop,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    t_back_state       r_state, n_state;
    logic [15:0]       r_cells [MAX_REQUESTS];
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_dropped, n_dropped;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_split, n_split;
    logic [15:0]       r_head, n_head;
    logic [15:0]       r_lastc, n_lastc;
    logic [17:0]       r_total, n_total;
    logic [MAX_REQUESTS-1:0] r_flags, n_flags;
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;

    logic              w_insert;
    logic [MAX_REQUESTS-1:0] w_gt;
    logic [CNT_W-1:0]  v_split;
    logic [15:0]       v_pos;
    logic [17:0]       v_step_total;
    logic [CNT_W-1:0]  v_idx_next;

    // Insertion: cells holding a larger value shift up by one.
    assign w_insert = (r_state == ST_IDLE) && !i_q_empty && (r_count < CNT_W'(MAX_REQUESTS));

    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) && (r_cells[i] > i_q_data.cylinder);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            for (int i = 0; i < MAX_REQUESTS; i++) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    r_cells[i] <= r_cells[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || CNT_W'(i) == r_count) begin
                    r_cells[i] <= i_q_data.cylinder;
                end
            end
        end
    end

    // Values for the request at the current walk index.
    assign v_pos        = f_clamp(r_cells[r_idx], r_lastc);
    assign v_step_total = r_total + 18'(f_dist(v_pos, r_head));
    assign v_idx_next   = CNT_W'(r_idx) + CNT_W'(1);

    // First request at or above the head, or the count when there is none.
    always_comb begin
        v_split = r_count;
        for (int i = MAX_REQUESTS - 1; i >= 0; i--) begin
            if (r_flags[i]) begin
                v_split = CNT_W'(i);
            end
        end
    end

    // Sequencer next state and result generation.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_idx       = r_idx;
        n_split     = r_split;
        n_head      = r_head;
        n_lastc     = r_lastc;
        n_total     = r_total;
        n_flags     = r_flags;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (w_insert) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_q_data.is_last) begin
                        n_head  = i_cfg.start_head;
                        n_lastc = i_cfg.last_cyl;
                        n_total = 18'd0;
                        n_state = ST_FLAGS;
                    end
                end
            end
            ST_FLAGS: begin
                for (int i = 0; i < MAX_REQUESTS; i++) begin
                    n_flags[i] = (CNT_W'(i) < r_count)
                              && (f_clamp(r_cells[i], r_lastc) >= r_head);
                end
                n_state = ST_SPLIT;
            end
            ST_SPLIT: begin
                n_split = v_split;
                if (v_split < r_count) begin
                    n_idx   = IDX_W'(v_split);
                    n_state = ST_UPPER;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_UPPER: begin
                n_res_valid = 1'b1;
                n_res       = '{position: v_pos, step_kind: KIND_SERVE,
                                total_seek: v_step_total, overflow: r_dropped, last: 1'b0};
                n_total     = v_step_total;
                n_head      = v_pos;
                n_idx       = IDX_W'(v_idx_next);
                if (v_idx_next == r_count) begin
                    n_state = ST_END;
                end
            end
            ST_END: begin
                n_res_valid = 1'b1;
                n_total     = r_total + 18'(f_dist(r_lastc, r_head));
                n_res       = '{position: r_lastc, step_kind: KIND_END,
                                total_seek: n_total, overflow: r_dropped, last: 1'b0};
                n_head      = r_lastc;
                n_state     = ST_ZERO;
            end
            ST_ZERO: begin
                n_res_valid = 1'b1;
                n_total     = r_total + 18'(r_lastc);
                n_res       = '{position: 16'd0, step_kind: KIND_ZERO, total_seek: n_total,
                                overflow: r_dropped, last: (r_split == CNT_W'(0))};
                n_head      = 16'd0;
                n_idx       = '0;
                if (r_split == CNT_W'(0)) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = ST_IDLE;
                end else begin
                    n_state = ST_LOWER;
                end
            end
            ST_LOWER: begin
                n_res_valid = 1'b1;
                n_res       = '{position: v_pos, step_kind: KIND_SERVE, total_seek: v_step_total,
                                overflow: r_dropped, last: (v_idx_next == r_split)};
                n_total     = v_step_total;
                n_head      = v_pos;
                n_idx       = IDX_W'(v_idx_next);
                if (v_idx_next == r_split) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_res_valid <= n_res_valid;
        end
    end

    // Walk and payload registers.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_split <= n_split;
        r_head  <= n_head;
        r_lastc <= n_lastc;
        r_total <= n_total;
        r_flags <= n_flags;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* rtl/cscan_disk_scheduler_top.sv */
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler top level
// Collects a batch of cylinder requests and emits their C-SCAN service order.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle while busy is low; they pass a two-entry
// queue and are inserted into a row of sorted cells at one per cycle while the
// back is idle. The request marked is_last ends the batch. When the queue holds
// nothing else, that request is written into the queue, then popped and inserted,
// the cells are compared with the head, the split is found and the first result
// is registered. Results then follow one per cycle, n+2 results for n stored
// requests, each shown for a single cycle on o_res with o_res_valid. Results
// cannot be held off. While a batch is being emitted the back stops draining
// the queue, so busy rises once two more requests are waiting. Configuration
// writes are always accepted and should be made only while the block is idle.
module cscan_disk_scheduler_top
    import cds_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_res_valid,
    output t_result              o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [16:0]          i_cfg_data
);

    logic w_push;
    t_req w_push_data;
    logic w_pop;
    t_req w_pop_data;
    logic w_q_empty;
    logic w_q_full;
    t_cfg w_cfg;

    // Intake and configuration.
    cds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .o_cfg       (w_cfg)
    );

    // Decoupling queue.
    cds_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_q_empty),
        .o_full      (w_q_full)
    );

    // Sorting and emission.
    cds_back #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_pop_data),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // The final result of a schedule is never directly followed by another.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |=> !o_res_valid)
        else $error("result emitted right after the final result");

    // The sweep to the disk end is always followed by the jump to zero.
    a_end_then_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.step_kind == KIND_END |=>
        o_res_valid && o_res.step_kind == KIND_ZERO)
        else $error("jump to cylinder zero missing after sweep end");

    // Within one schedule the running seek total never decreases.
    a_seek_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && $past(o_res_valid) && !$past(o_res.last) |->
        o_res.total_seek >= $past(o_res.total_seek))
        else $error("total seek decreased within a schedule");

endmodule

/* tb/sv/cscan_order_checker.sv */
// ----------------------------------------------------------------------------
// C-SCAN service order checker
// Watches the request, result and configuration channels of the scheduler,
// predicts the service order of every batch and compares each result with it.
// ----------------------------------------------------------------------------
module cscan_order_checker
    import cds_pkg::*;
#(
    parameter int MAX_REQ = MAX_REQUESTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_req                 i_req,
    input  logic                 i_res_valid,
    input  t_result              i_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [16:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the configuration registers.
    int unsigned head_cfg;
    int unsigned size_cfg;

    // Shadow of the sorted request store of the current batch.
    logic [15:0] cyl_cells [MAX_REQ];
    int          cell_count;
    bit          batch_dropped;

    // Service order still to be seen on the result channel, oldest first.
    t_result     service_order_q [$];
    int          fails = 0;

    // Last cylinder, with a zero size acting as one and large sizes saturating.
    function automatic int unsigned last_cyl();
        int unsigned s;
        s = size_cfg;
        if (s == 0) s = 1;
        if (s > 65536) s = 65536;
        return s - 1;
    endfunction

    function automatic int unsigned seek_dist(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned clamp_cyl(input int unsigned c, input int unsigned lastc);
        return (c > lastc) ? lastc : c;
    endfunction

    task automatic push_step(input int unsigned pos, input logic [1:0] kind,
                             input int unsigned total, input bit is_end);
        t_result r;
        r.position   = pos[15:0];
        r.step_kind  = kind;
        r.total_seek = total[17:0];
        r.overflow   = batch_dropped;
        r.last       = is_end;
        service_order_q.push_back(r);
    endtask

    // Stores one request in sorted order; a batch end produces its service order.
    task automatic schedule_request(input t_req r);
        int unsigned lastc;
        int unsigned cyl;
        int unsigned pos;
        int unsigned at;
        int unsigned total;
        int          j;
        int          split;
        lastc = last_cyl();
        cyl   = clamp_cyl({16'd0, r.cylinder}, lastc);
        if (cell_count < MAX_REQ) begin
            j = cell_count;
            while (j > 0 && cyl_cells[j-1] > cyl) begin
                cyl_cells[j] = cyl_cells[j-1];
                j--;
            end
            cyl_cells[j] = cyl[15:0];
            cell_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (!r.is_last) return;

        // Find the first stored request at or above the head.
        split = cell_count;
        for (j = 0; j < cell_count; j++) begin
            if (clamp_cyl({16'd0, cyl_cells[j]}, lastc) >= head_cfg) begin
                split = j;
                break;
            end
        end

        // Upward sweep, then the disk end and the wrap to cylinder zero.
        at    = head_cfg;
        total = 0;
        for (j = split; j < cell_count; j++) begin
            pos    = clamp_cyl({16'd0, cyl_cells[j]}, lastc);
            total += seek_dist(pos, at);
            at     = pos;
            push_step(pos, KIND_SERVE, total, 1'b0);
        end
        total += seek_dist(lastc, at);
        push_step(lastc, KIND_END, total, 1'b0);
        total += lastc;
        at     = 0;
        push_step(0, KIND_ZERO, total, split == 0);

        // Requests below the head are served after the wrap.
        for (j = 0; j < split; j++) begin
            pos    = clamp_cyl({16'd0, cyl_cells[j]}, lastc);
            total += seek_dist(pos, at);
            at     = pos;
            push_step(pos, KIND_SERVE, total, j + 1 == split);
        end
        cell_count    = 0;
        batch_dropped = 1'b0;
    endtask

    // Compares one result transaction with the oldest expected step.
    task automatic check_result(input t_result got);
        t_result want;
        if (service_order_q.size() == 0) begin
            $error("unexpected result: position %0d, step_kind %0d",
                   got.position, got.step_kind);
            fails++;
            return;
        end
        want = service_order_q.pop_front();
        if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            fails++;
        end
        if (got.step_kind !== want.step_kind) begin
            $error("step_kind: expected %0d, actual %0d", want.step_kind, got.step_kind);
            fails++;
        end
        if (got.total_seek !== want.total_seek) begin
            $error("total_seek: expected %0d, actual %0d", want.total_seek, got.total_seek);
            fails++;
        end
        if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
            fails++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fails++;
        end
    endtask

    // Sample all channels at the rising edge and advance the prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_cfg      = 0;
            size_cfg      = {15'd0, DISK_SIZE_RST};
            cell_count    = 0;
            batch_dropped = 1'b0;
            service_order_q.delete();
        end else begin
            if (i_res_valid) begin
                check_result(i_res);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_HEAD: head_cfg = {16'd0, i_cfg_data[15:0]};
                    CFG_DISK_SIZE:  size_cfg = {15'd0, i_cfg_data};
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                schedule_request(i_req);
            end
        end
        o_pending    <= service_order_q.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/tb_cscan_disk_scheduler_top.sv */
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler testbench
// Sends directed and random request batches with random gaps, changes the
// disk geometry between batches and lets the checker verify every result.
// ----------------------------------------------------------------------------
module tb_cscan_disk_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cds_pkg::*;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    t_req                 req       = '0;
    logic                 res_valid;
    t_result              res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_HEAD;
    logic [16:0]          cfg_data  = '0;
    int                   fail_count;
    int                   pending;

    // Stimulus side copy of the geometry, used to aim cylinders.
    int unsigned          cur_head = 0;
    int unsigned          cur_size = 200;
    bit                   no_gaps  = 1'b0;

    always #10 i_clk = ~i_clk;

    cscan_disk_scheduler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cscan_order_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Cylinders aimed inside the disk, at the head, at the end, or anywhere.
    function automatic logic [15:0] pick_cyl();
        int unsigned lastc;
        int          sel;
        lastc = (cur_size == 0) ? 0 : ((cur_size > 65536) ? 65535 : cur_size - 1);
        sel   = $urandom_range(0, 9);
        if (sel < 5) return 16'($urandom_range(0, lastc));
        if (sel < 7) return 16'($urandom_range(0, 65535));
        if (sel == 7) return cur_head[15:0];
        if (sel == 8) return lastc[15:0];
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    // One request transaction followed by a random gap.
    task automatic send_item(input logic [15:0] cyl, input logic is_last);
        int gap;
        start <= 1'b1;
        req   <= '{cylinder: cyl, is_last: is_last};
        do @(posedge i_clk); while (busy);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected result is in and the insert pipe is empty.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes both geometry registers back to back.
    task automatic set_regs(input logic [15:0] head, input logic [16:0] size);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START_HEAD;
        cfg_data  <= {1'b0, head};
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= CFG_DISK_SIZE;
        cfg_data  <= size;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_head  = {16'd0, head};
        cur_size  = {15'd0, size};
    endtask

    task automatic new_config();
        logic [16:0] size;
        logic [15:0] head;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            size = 17'($urandom_range(2, 400));
        end else if (sel < 7) begin
            size = 17'($urandom_range(1, 65536));
        end else if (sel == 7) begin
            size = 17'($urandom);
        end else begin
            case ($urandom_range(0, 4))
                0: size = 17'd0;
                1: size = 17'd1;
                2: size = 17'd65536;
                3: size = 17'd65537;
                default: size = 17'h1FFFF;
            endcase
        end
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            head = 16'($urandom_range(0, (size > 65535) ? 65535 : size));
        end else if (sel < 7) begin
            head = 16'($urandom);
        end else if (sel == 7) begin
            head = 16'h0000;
        end else begin
            head = 16'hFFFF;
        end
        set_regs(head, size);
    endtask

    // Watchdog for a hung run.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int   items_sent;
        int   len;
        int   sel;
        int   k;
        bit   first;
        logic last_flag;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry; a request at the head and one beyond the disk end.
        send_item(16'd50, 1'b0);
        send_item(16'd199, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd0, 1'b1);
        // A batch of a single request.
        send_item(16'd77, 1'b1);

        // Requests on both sides of the head, one exactly on it.
        drain();
        set_regs(16'd100, 17'd200);
        send_item(16'd150, 1'b0);
        send_item(16'd20, 1'b0);
        send_item(16'd100, 1'b0);
        send_item(16'd180, 1'b0);
        send_item(16'd5, 1'b1);

        // Nothing at or above the head: everything is served after the wrap.
        drain();
        set_regs(16'd150, 17'd200);
        send_item(16'd10, 1'b0);
        send_item(16'd20, 1'b1);

        // Head past the disk end: the sweep to the end goes downward.
        drain();
        set_regs(16'hFFFF, 17'd1000);
        send_item(16'd500, 1'b0);
        send_item(16'd999, 1'b1);

        // A zero disk size acts as a single cylinder.
        drain();
        set_regs(16'd40, 17'd0);
        send_item(16'd7, 1'b1);

        // An oversized disk saturates at the full cylinder range.
        drain();
        set_regs(16'd0, 17'h1FFFF);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd0, 1'b1);

        // Disk shrinks mid batch, so stored requests are clamped again.
        drain();
        set_regs(16'd0, 17'd65536);
        send_item(16'd60000, 1'b0);
        send_item(16'd40000, 1'b0);
        drain();
        set_regs(16'd0, 17'd30000);
        send_item(16'd10, 1'b1);

        drain();
        set_regs(16'd120, 17'd250);

        // Random batches; the first one overflows the store, so its last two requests are dropped.
        items_sent = 0;
        first      = 1'b1;
        while (items_sent < 250) begin
            sel     = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (first) begin
                len = 34;
            end else if (sel < 8) begin
                len = $urandom_range(30, 40);
            end else begin
                len = $urandom_range(1, 8);
            end
            for (k = 0; k < len; k++) begin
                if (!first && sel >= 90) begin
                    last_flag = ($urandom_range(0, 3) == 0);
                end else begin
                    last_flag = (k == len - 1);
                end
                send_item(pick_cyl(), last_flag);
            end
            items_sent += len;
            first       = 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                drain();
                if ($urandom_range(0, 2) != 0) new_config();
            end
        end
        no_gaps = 1'b0;

        // Let the last schedule come out, with a bound.
        start <= 1'b0;
        @(posedge i_clk);
        for (k = 0; k < 5000 && pending != 0; k++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
